>>> hdl/prf_pkg.sv
// Shared constants and types for the point region-of-interest filter.
package prf_pkg;

  localparam int ADDR_BITS = 5;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_CROP_X      = 3'd0;
  localparam reg_idx_t REG_CROP_Y      = 3'd1;
  localparam reg_idx_t REG_CROP_Z      = 3'd2;
  localparam reg_idx_t REG_AREA_CENTER = 3'd3;
  localparam reg_idx_t REG_AREA_RADIUS = 3'd4;
  localparam reg_idx_t REG_AREA_SECTOR = 3'd5;
  localparam reg_idx_t REG_ZONE_X      = 3'd6;
  localparam reg_idx_t REG_ZONE_Y      = 3'd7;

  localparam int CORDIC_STEPS = 24;
  localparam int PRE_SHIFT    = 24;
  localparam int SEED_BITS    = 18;
  localparam int CORW         = 45;

  localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage

>>> hdl/point_roi_filter_top.sv
// Point region-of-interest filter: crop box, radius and sector, exclusion zone.
//
// Usage: one lidar point (point_x, point_y, point_z) enters on the input
// channel per accepted item (in_valid high, in_stall low at a clock edge).
// One result item (keep) leaves on the output channel for every input item,
// in order, accepted when out_valid is high and out_stall is low.
// Registers are written through the APB port; write them only while no item
// is in flight.
// Throughput: one item per cycle while the output is not stalled. The path
// is the input stage, the crop/offset and distance stages, the 24-stage
// CORDIC angle pipeline, and the rounding and sector stages.
// When out_stall holds a waiting result, the whole pipeline holds; one more
// input item is still taken into a skid register, after which in_stall rises
// until the pipeline moves again.
// Reset (rst, synchronous) clears all valid bits and loads register defaults:
// full crop box, area and zone checks disabled.
module point_roi_filter_top
  import prf_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         keep,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CW    = (COORD_BITS > 16 ? COORD_BITS : 16) + 1;
  localparam int EXT16 = CW - 16;
  localparam int EXTC  = CW - COORD_BITS;
  localparam logic [31:0] RND_HALF = 32'd1 << (31 - ANGLE_BITS);
  localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic [31:0] crop_x, crop_y, crop_z, area_center, area_sector, zone_x, zone_y;
  logic [17:0] area_radius_and_enables;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     area_en, zone_en;
  logic [15:0] radius;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_BITS-1:2];
  assign area_en = area_radius_and_enables[16];
  assign zone_en = area_radius_and_enables[17];
  assign radius  = area_radius_and_enables[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_x                  <= 32'h7FFF_8000;
      crop_y                  <= 32'h7FFF_8000;
      crop_z                  <= 32'h7FFF_8000;
      area_center             <= '0;
      area_radius_and_enables <= '0;
      area_sector             <= '0;
      zone_x                  <= '0;
      zone_y                  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CROP_X:      crop_x <= pwdata;
        REG_CROP_Y:      crop_y <= pwdata;
        REG_CROP_Z:      crop_z <= pwdata;
        REG_AREA_CENTER: area_center <= pwdata;
        REG_AREA_RADIUS: area_radius_and_enables <= pwdata[17:0];
        REG_AREA_SECTOR: area_sector <= pwdata;
        REG_ZONE_X:      zone_x <= pwdata;
        REG_ZONE_Y:      zone_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CROP_X:      prdata = crop_x;
      REG_CROP_Y:      prdata = crop_y;
      REG_CROP_Z:      prdata = crop_z;
      REG_AREA_CENTER: prdata = area_center;
      REG_AREA_RADIUS: prdata = {14'd0, area_radius_and_enables};
      REG_AREA_SECTOR: prdata = area_sector;
      REG_ZONE_X:      prdata = zone_x;
      REG_ZONE_Y:      prdata = zone_y;
      default:         prdata = '0;
    endcase
  end

  function automatic logic signed [CW-1:0] sx16(input logic [15:0] v);
    return {{EXT16{v[15]}}, v};
  endfunction

  function automatic logic signed [CW-1:0] sxc(input logic [COORD_BITS-1:0] v);
    return {{EXTC{v[COORD_BITS-1]}}, v};
  endfunction

  // Pipeline advance and input skid.
  logic en, accept;
  logic s_valid;
  logic [COORD_BITS-1:0] s_x, s_y, s_z;

  assign en       = !(out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign in_stall = s_valid;

  // Stage A: input register.
  logic a_valid;
  logic [COORD_BITS-1:0] a_x, a_y, a_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_valid || accept;
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x <= s_valid ? s_x : point_x;
      a_y <= s_valid ? s_y : point_y;
      a_z <= s_valid ? s_z : point_z;
    end
    if (!en && accept) begin
      s_x <= point_x;
      s_y <= point_y;
      s_z <= point_z;
    end
  end

  // Stage B: crop box, exclusion zone, offset from area centre.
  logic signed [CW-1:0] xe, ye, ze;
  logic crop_ok, zone_in;
  logic b_valid, b_crop_ok, b_zone_ok;
  logic signed [CW-1:0] b_dx, b_dy;

  assign xe = sxc(a_x);
  assign ye = sxc(a_y);
  assign ze = sxc(a_z);

  assign crop_ok = xe >= sx16(crop_x[15:0]) && xe < sx16(crop_x[31:16]) &&
                   ye >= sx16(crop_y[15:0]) && ye < sx16(crop_y[31:16]) &&
                   ze >= sx16(crop_z[15:0]) && ze < sx16(crop_z[31:16]);
  assign zone_in = xe >= sx16(zone_x[15:0]) && xe <= sx16(zone_x[31:16]) &&
                   ye >= sx16(zone_y[15:0]) && ye <= sx16(zone_y[31:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      b_crop_ok <= crop_ok;
      b_zone_ok <= !(zone_en && zone_in);
      b_dx      <= xe - sx16(area_center[15:0]);
      b_dy      <= ye - sx16(area_center[31:16]);
    end
  end

  // Stage C: box distance, squares, CORDIC seed.
  logic [CW-1:0] ax, ay;
  logic near, neg;
  logic signed [SEED_BITS-1:0] dxt, dyt, xi, yi;
  logic [31:0] c_sqx, c_sqy, c_rsq;

  assign ax   = b_dx[CW-1] ? CW'(-b_dx) : CW'(b_dx);
  assign ay   = b_dy[CW-1] ? CW'(-b_dy) : CW'(b_dy);
  assign near = ax <= CW'(radius) && ay <= CW'(radius);
  assign neg  = b_dx[CW-1];
  assign dxt  = SEED_BITS'(b_dx);
  assign dyt  = SEED_BITS'(b_dy);
  assign xi   = neg ? -dxt : dxt;
  assign yi   = neg ? -dyt : dyt;

  logic                   cv    [0:CORDIC_STEPS];
  logic                   cp    [0:CORDIC_STEPS];
  logic                   czero [0:CORDIC_STEPS];
  logic signed [CORW-1:0] cx    [0:CORDIC_STEPS];
  logic signed [CORW-1:0] cy    [0:CORDIC_STEPS];
  logic [31:0]            cz    [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      c_sqx    <= ax[15:0] * ax[15:0];
      c_sqy    <= ay[15:0] * ay[15:0];
      c_rsq    <= radius * radius;
      cp[0]    <= b_crop_ok && b_zone_ok && (!area_en || near);
      czero[0] <= b_dx == '0 && b_dy == '0;
      cx[0]    <= {{(CORW-SEED_BITS-PRE_SHIFT){xi[SEED_BITS-1]}}, xi, {PRE_SHIFT{1'b0}}};
      cy[0]    <= {{(CORW-SEED_BITS-PRE_SHIFT){yi[SEED_BITS-1]}}, yi, {PRE_SHIFT{1'b0}}};
      cz[0]    <= neg ? 32'h8000_0000 : 32'h0000_0000;
    end
  end

  logic dist_ok;
  assign dist_ok = !area_en || ({1'b0, c_sqx} + {1'b0, c_sqy} <= {1'b0, c_rsq});

  // CORDIC vectoring, one rotation per stage.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [CORW-1:0] xs, ys;
    assign xs = cx[k] >>> k;
    assign ys = cy[k] >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else if (en) begin
        cv[k+1] <= cv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cp[k+1]    <= cp[k] && (k != 0 || dist_ok);
        czero[k+1] <= czero[k];
        if (!cy[k][CORW-1]) begin
          cx[k+1] <= cx[k] + ys;
          cy[k+1] <= cy[k] - xs;
          cz[k+1] <= cz[k] + ATAN_TURNS[k];
        end else begin
          cx[k+1] <= cx[k] - ys;
          cy[k+1] <= cy[k] + xs;
          cz[k+1] <= cz[k] - ATAN_TURNS[k];
        end
      end
    end
  end

  // Stage E: round the angle.
  logic e_valid, e_pre;
  logic [31:0] e_ang;

  always_ff @(posedge clk) begin
    if (en) begin
      e_pre <= cp[CORDIC_STEPS];
      e_ang <= czero[CORDIC_STEPS] ? 32'd0 : ((cz[CORDIC_STEPS] + RND_HALF) & ANG_MASK);
    end
  end

  // Stage F: sector test and output register.
  logic [31:0] diff, lim;
  logic sector_ok;

  assign diff      = e_ang - {area_sector[15:0], 16'h0000};
  assign lim       = {1'b0, area_sector[31:16], 15'd0};
  assign sector_ok = $signed(diff) <= $signed(lim) && $signed(diff) >= -$signed(lim);

  always_ff @(posedge clk) begin
    if (en) begin
      keep <= e_pre && (!area_en || sector_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      cv[0]     <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b_valid   <= a_valid;
      cv[0]     <= b_valid;
      e_valid   <= cv[CORDIC_STEPS];
      out_valid <= e_valid;
    end
  end

endmodule

>>> hdl/prf_checker.sv
// Port-level checks for the point region-of-interest filter, bound to the top level.
module prf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic keep
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(keep))
    else $error("output item changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("valid or stall set after reset");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    in_stall && !(out_valid && out_stall) |=> !in_stall)
    else $error("input stall held while pipeline advanced");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(in_stall) && in_stall |->
      $past(out_valid && out_stall && in_valid))
    else $error("input stall rose without an output stall");

endmodule

bind point_roi_filter_top prf_checker u_prf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .keep      (keep)
);

>>> dv/testbench.sv
// Self-checking testbench for the point region-of-interest filter top level.
`timescale 1ns / 100ps

module testbench;
  import prf_pkg::*;

  localparam int COORD_BITS   = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_POINTS = 165;

  localparam logic [31:0] TURN_STEPS [0:23] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_BITS-1:0] point_x = '0;
  logic signed [COORD_BITS-1:0] point_y = '0;
  logic signed [COORD_BITS-1:0] point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic keep;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [31:0] roi_regs [0:7];
  point_t pending_points [$];
  bit expected_keep [$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int points_checked = 0;
  int points_kept = 0;
  int settings_count = 0;
  int cycle_count = 0;

  point_roi_filter_top #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .keep(keep),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int lo_half(logic [31:0] r);
    return int'($signed(r[15:0]));
  endfunction

  function automatic int hi_half(logic [31:0] r);
    return int'($signed(r[31:16]));
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic logic [31:0] span_reg(int lo, int hi);
    return {hi[15:0], lo[15:0]};
  endfunction

  function automatic int pick_between(int lo, int hi);
    if (lo > hi) return hi + int'($urandom_range(lo - hi));
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int pick_edge(int lo, int hi);
    case ($urandom_range(6))
      0: return lo - 1;
      1: return lo;
      2: return lo + 1;
      3: return hi - 1;
      4: return hi;
      5: return hi + 1;
      default: return pick_between(lo, hi);
    endcase
  endfunction

  // Bearing from the area centre in 2^-32 turn, rounded to ANGLE_BITS.
  function automatic logic [31:0] point_bearing(longint dx, longint dy);
    longint ux, uy, sx, sy;
    logic [31:0] turns;
    if (dx == 0 && dy == 0) return '0;
    ux = dx * 16777216;
    uy = dy * 16777216;
    turns = '0;
    if (ux < 0) begin
      ux = -ux;
      uy = -uy;
      turns = 32'h8000_0000;
    end
    for (int i = 0; i < 24; i++) begin
      sx = ux >>> i;
      sy = uy >>> i;
      if (uy >= 0) begin
        ux += sy;
        uy -= sx;
        turns += TURN_STEPS[i];
      end else begin
        ux -= sy;
        uy += sx;
        turns -= TURN_STEPS[i];
      end
    end
    turns += 32'd1 << (31 - ANGLE_BITS);
    return turns & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  endfunction

  function automatic bit predict_keep(logic signed [COORD_BITS-1:0] px,
                                      logic signed [COORD_BITS-1:0] py,
                                      logic signed [COORD_BITS-1:0] pz);
    longint x, y, z, dx, dy, r, ax, ay, off;
    logic [31:0] diff;
    bit passes;
    x = px;
    y = py;
    z = pz;
    passes = x >= lo_half(roi_regs[REG_CROP_X]) && x < hi_half(roi_regs[REG_CROP_X]) &&
             y >= lo_half(roi_regs[REG_CROP_Y]) && y < hi_half(roi_regs[REG_CROP_Y]) &&
             z >= lo_half(roi_regs[REG_CROP_Z]) && z < hi_half(roi_regs[REG_CROP_Z]);
    if (passes && roi_regs[REG_AREA_RADIUS][16]) begin
      dx = x - lo_half(roi_regs[REG_AREA_CENTER]);
      dy = y - hi_half(roi_regs[REG_AREA_CENTER]);
      r = longint'(roi_regs[REG_AREA_RADIUS][15:0]);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax > r || ay > r || ax * ax + ay * ay > r * r) begin
        passes = 1'b0;
      end else begin
        diff = point_bearing(dx, dy) - {roi_regs[REG_AREA_SECTOR][15:0], 16'h0000};
        off = $signed(diff);
        if (off < 0) off = -off;
        passes = off <= (longint'(roi_regs[REG_AREA_SECTOR][31:16]) << 15);
      end
    end
    if (passes && roi_regs[REG_AREA_RADIUS][17] &&
        x >= lo_half(roi_regs[REG_ZONE_X]) && x <= hi_half(roi_regs[REG_ZONE_X]) &&
        y >= lo_half(roi_regs[REG_ZONE_Y]) && y <= hi_half(roi_regs[REG_ZONE_Y]))
      passes = 1'b0;
    return passes;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_keep.push_back(predict_keep(point_x, point_y, point_z));
      if (!in_valid || !in_stall) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          point_x <= pending_points[0].x;
          point_y <= pending_points[0].y;
          point_z <= pending_points[0].z;
          void'(pending_points.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    bit want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_keep.size() == 0) begin
          $display("%0t: keep expected none, got %0b", $time, keep);
          mismatches++;
        end else begin
          want = expected_keep.pop_front();
          if (keep !== want) begin
            $display("%0t: keep expected %0b, got %0b", $time, want, keep);
            mismatches++;
          end
          points_checked++;
          if (want) points_kept++;
        end
      end
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= $urandom_range(99) < receiver_stall_pct;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("point_roi_filter_top: mismatch");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    roi_regs[idx] = (idx == REG_AREA_RADIUS) ? (value & 32'h0003_FFFF) : value;
  endtask

  task automatic program_roi(logic [31:0] crop_x, logic [31:0] crop_y,
                             logic [31:0] crop_z, logic [31:0] center,
                             logic [31:0] radius_en, logic [31:0] sector,
                             logic [31:0] zone_x, logic [31:0] zone_y);
    write_reg(REG_CROP_X, crop_x);
    write_reg(REG_CROP_Y, crop_y);
    write_reg(REG_CROP_Z, crop_z);
    write_reg(REG_AREA_CENTER, center);
    write_reg(REG_AREA_RADIUS, radius_en);
    write_reg(REG_AREA_SECTOR, sector);
    write_reg(REG_ZONE_X, zone_x);
    write_reg(REG_ZONE_Y, zone_y);
    settings_count++;
  endtask

  task automatic queue_point(int x, int y, int z);
    point_t p;
    p.x = COORD_BITS'(clamp_coord(x));
    p.y = COORD_BITS'(clamp_coord(y));
    p.z = COORD_BITS'(clamp_coord(z));
    pending_points.push_back(p);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_points.size() != 0 || in_valid || expected_keep.size() != 0);
  endtask

  task automatic program_random_roi(int phase);
    int cx, cy, rad, xlo, xhi, ylo, yhi, zlo, zhi, zxlo, zxhi, zylo, zyhi, t;
    int bearing, fov;
    logic [1:0] enables;
    cx = int'($urandom_range(4000)) - 2000;
    cy = int'($urandom_range(4000)) - 2000;
    rad = $urandom_range(3000, 20);
    xlo = clamp_coord(cx - int'($urandom_range(3000)));
    xhi = clamp_coord(cx + int'($urandom_range(3000, 1)));
    ylo = clamp_coord(cy - int'($urandom_range(3000)));
    yhi = clamp_coord(cy + int'($urandom_range(3000, 1)));
    zlo = -int'($urandom_range(500));
    zhi = $urandom_range(500, 1);
    if ($urandom_range(9) == 0) begin
      t = xlo;
      xlo = xhi;
      xhi = t;
    end
    if ($urandom_range(3) == 0) begin
      xlo = -32768;
      xhi = 32767;
      ylo = -32768;
      yhi = 32767;
    end
    zxlo = clamp_coord(cx + int'($urandom_range(2 * rad)) - rad);
    zxhi = clamp_coord(zxlo + int'($urandom_range(rad)));
    zylo = clamp_coord(cy + int'($urandom_range(2 * rad)) - rad);
    zyhi = clamp_coord(zylo + int'($urandom_range(rad)));
    if ($urandom_range(9) == 0) begin
      t = zylo;
      zylo = zyhi;
      zyhi = t;
    end
    enables = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b11;
    bearing = $urandom_range(65535);
    fov = $urandom_range(65535);
    case (phase)
      0: begin
        cx = -32768;
        cy = 32767;
        rad = 65535;
        xlo = -32768;
        xhi = 32767;
        ylo = -32768;
        yhi = 32767;
        enables = 2'b01;
      end
      1: rad = 0;
      2: begin
        fov = 65535;
        bearing = 65535;
      end
      3: begin
        xlo = -32768;
        xhi = 32767;
        ylo = -32768;
        yhi = 32767;
        zlo = -32768;
        zhi = 32767;
        enables = 2'b00;
      end
      default: ;
    endcase
    program_roi(span_reg(xlo, xhi), span_reg(ylo, yhi), span_reg(zlo, zhi),
                span_reg(cx, cy), {14'b0, enables, rad[15:0]},
                {fov[15:0], bearing[15:0]}, span_reg(zxlo, zxhi), span_reg(zylo, zyhi));
  endtask

  task automatic queue_random_points(int count);
    int cx, cy, rad, span, zl, zh;
    cx = lo_half(roi_regs[REG_AREA_CENTER]);
    cy = hi_half(roi_regs[REG_AREA_CENTER]);
    rad = int'(roi_regs[REG_AREA_RADIUS][15:0]);
    span = rad + rad / 4 + 2;
    zl = lo_half(roi_regs[REG_CROP_Z]);
    zh = hi_half(roi_regs[REG_CROP_Z]);
    repeat (count) begin
      case ($urandom_range(7))
        0, 1: queue_point(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                          int'($signed(16'($urandom))));
        2, 3, 4, 5: queue_point(cx + int'($urandom_range(2 * span)) - span,
                                cy + int'($urandom_range(2 * span)) - span,
                                pick_between(zl, zh));
        6: queue_point(pick_edge(lo_half(roi_regs[REG_CROP_X]), hi_half(roi_regs[REG_CROP_X])),
                       pick_edge(lo_half(roi_regs[REG_CROP_Y]), hi_half(roi_regs[REG_CROP_Y])),
                       pick_edge(zl, zh));
        default: queue_point(
          pick_edge(lo_half(roi_regs[REG_ZONE_X]), hi_half(roi_regs[REG_ZONE_X])),
          pick_edge(lo_half(roi_regs[REG_ZONE_Y]), hi_half(roi_regs[REG_ZONE_Y])),
          pick_between(zl, zh));
      endcase
    end
  endtask

  initial begin
    roi_regs[REG_CROP_X] = 32'h7FFF_8000;
    roi_regs[REG_CROP_Y] = 32'h7FFF_8000;
    roi_regs[REG_CROP_Z] = 32'h7FFF_8000;
    roi_regs[REG_AREA_CENTER] = '0;
    roi_regs[REG_AREA_RADIUS] = '0;
    roi_regs[REG_AREA_SECTOR] = '0;
    roi_regs[REG_ZONE_X] = '0;
    roi_regs[REG_ZONE_Y] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 18;
    receiver_stall_pct = 72;

    // full crop box after reset: minimum kept, maximum dropped
    queue_point(-32768, -32768, -32768);
    queue_point(32767, 0, 0);
    queue_point(0, 32767, 0);
    queue_point(0, 0, 32767);
    queue_point(32766, 32766, 32766);
    queue_point(-1, -1, -1);
    wait_idle();

    // radius, quarter-turn sector and closed exclusion zone
    program_roi(span_reg(-100, 100), span_reg(-100, 100), span_reg(-5, 5),
                span_reg(10, -20), 32'h0003_0032, 32'h8000_4000,
                span_reg(20, 30), span_reg(0, 10));
    queue_point(10, -20, 0);
    queue_point(10, 30, 0);
    queue_point(10, 31, 0);
    queue_point(40, 20, 0);
    queue_point(41, 20, 0);
    queue_point(20, 0, 0);
    queue_point(30, 10, 0);
    queue_point(19, 0, -5);
    queue_point(60, -20, 4);
    queue_point(-40, -20, 5);
    queue_point(10, -21, 0);
    wait_idle();

    // zero field of view and inverted exclusion zone
    program_roi(span_reg(-32768, 32767), span_reg(-32768, 32767), span_reg(-32768, 32767),
                32'h0000_0000, 32'h0003_FFFF, 32'h0000_2000,
                span_reg(10, -10), span_reg(-10, 10));
    queue_point(100, 100, 0);
    queue_point(100, 101, 0);
    queue_point(0, 0, 0);
    queue_point(5, 5, 0);
    wait_idle();

    // inverted crop box
    program_roi(span_reg(10, -10), span_reg(-32768, 32767), span_reg(-32768, 32767),
                32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_point(0, 0, 0);
    queue_point(10, 0, 0);
    queue_point(-10, 0, 0);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 3) begin
        sender_idle_pct = 18;
        receiver_stall_pct = 72;
      end else if (phase < 6) begin
        sender_idle_pct = 72;
        receiver_stall_pct = 18;
      end else begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      program_random_roi(phase);
      if (phase == 6) long_hold_req = 1'b1;
      queue_random_points(PHASE_POINTS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d points under %0d register settings (%0d kept, %0d dropped).",
             points_checked, settings_count + 1, points_kept, points_checked - points_kept);
    if (mismatches == 0)
      $display("point_roi_filter_top: match");
    else
      $display("point_roi_filter_top: mismatch");
    $finish;
  end

endmodule
